[sv/sfr_pkg.sv]
package sfr_pkg;

  localparam logic [7:0] START_BYTE  = 8'h01;
  localparam logic [7:0] ALIGN_BYTE  = 8'h01;
  localparam logic [7:0] FOOTER_BYTE = 8'h04;
  localparam logic [7:0] ADDR_MAX    = 8'd32;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_CHK_ERR    = 2'd1;
  localparam logic [1:0] STATUS_FOOTER_ERR = 2'd2;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [5:0] target_address;
    logic [5:0] sender_address;
    logic [1:0] frame_status;
    logic       frame_last;
  } sfr_result_t;

endpackage

[sv/sfr_in_if.sv]
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/sfr_out_if.sv]
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [5:0] target_address;
  logic [5:0] sender_address;
  logic [1:0] frame_status;
  logic       frame_last;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output target_address, output sender_address, output frame_status,
    output frame_last, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input target_address, input sender_address, input frame_status,
    input frame_last, output ready
  );
endinterface

[sv/serial_frame_receiver_checksum.sv]
// Serial frame receiver with additive checksum.
// in_ch carries one received byte per transaction (valid/ready). The block
// hunts for start 0x01, target, sender, align 0x01, length, payload,
// checksum, footer 0x04. Each payload byte leaves on out_ch as a payload
// result; a frame that reaches its checksum closes with one frame end result
// carrying its status (good, checksum mismatch, footer missing). Bad start or
// align bytes and headers with an address above 32 produce no result.
// Throughput: one byte per cycle while the skid register is empty (in_ch.ready
// high), handled by the frame state machine and its one 8-bit running-sum adder.
// Results are registered: a result enters the result register, or the skid
// register while the result register holds one that is not yet taken.
// Output: a result register backed by one skid register. in_ch.ready stays
// high while the skid register is empty, so a byte is taken while a result
// waits; when the receiver stalls and both hold results, ready drops until
// out_ch.ready frees a slot. Nothing is lost or repeated.
// Reset (rst_n low, synchronous): hunting for start, sum and counters cleared,
// both output slots empty.
module serial_frame_receiver_checksum (
  input  logic          clk,
  input  logic          rst_n,
  sfr_in_if.sink        in_ch,
  sfr_out_if.source     out_ch
);
  import sfr_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TARGET  = 3'd1;
  localparam logic [2:0] PH_SENDER  = 3'd2;
  localparam logic [2:0] PH_ALIGN   = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;
  localparam logic [2:0] PH_FOOTER  = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  target_r, target_nxt;
  logic [7:0]  sender_r, sender_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  sfr_result_t out_r, out_nxt;
  sfr_result_t skid_r, skid_nxt;

  logic        accept;
  logic        pop;
  logic        has_res;
  sfr_result_t res;
  logic [7:0]  b;
  logic [7:0]  sum_add;

  assign b        = in_ch.rx_byte;
  assign in_ch.ready = !skid_valid_r;
  assign accept   = in_ch.valid && !skid_valid_r;
  assign pop      = out_valid_r && out_ch.ready;
  assign sum_add  = sum_r + b;

  always_comb begin
    phase_nxt  = phase_r;
    target_nxt = target_r;
    sender_nxt = sender_r;
    length_nxt = length_r;
    seen_nxt   = seen_r;
    sum_nxt    = sum_r;
    has_res    = 1'b0;
    res.result_kind    = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.target_address = target_r[5:0];
    res.sender_address = sender_r[5:0];
    res.frame_status   = STATUS_OK;
    res.frame_last     = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          sum_nxt   = b;
          seen_nxt  = 8'd0;
          phase_nxt = PH_TARGET;
        end
      end
      PH_TARGET: begin
        target_nxt = b;
        sum_nxt    = sum_add;
        phase_nxt  = PH_SENDER;
      end
      PH_SENDER: begin
        sender_nxt = b;
        sum_nxt    = sum_add;
        phase_nxt  = PH_ALIGN;
      end
      PH_ALIGN: begin
        if (b != ALIGN_BYTE) begin
          phase_nxt = PH_HUNT;
        end else begin
          sum_nxt   = sum_add;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (target_r > ADDR_MAX || sender_r > ADDR_MAX) begin
          phase_nxt = PH_HUNT;
        end else begin
          length_nxt = b;
          seen_nxt   = 8'd0;
          sum_nxt    = sum_add;
          phase_nxt  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        has_res           = 1'b1;
        res.payload_byte  = b;
        res.payload_index = seen_r;
        sum_nxt           = sum_add;
        seen_nxt          = seen_r + 8'd1;
        if (seen_nxt == length_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b != 8'(START_BYTE - sum_r)) begin
          has_res          = 1'b1;
          res.result_kind  = KIND_FRAME_END;
          res.frame_status = STATUS_CHK_ERR;
          res.frame_last   = 1'b1;
          phase_nxt        = PH_HUNT;
        end else begin
          phase_nxt = PH_FOOTER;
        end
      end
      PH_FOOTER: begin
        has_res          = 1'b1;
        res.result_kind  = KIND_FRAME_END;
        res.frame_status = (b == FOOTER_BYTE) ? STATUS_OK : STATUS_FOOTER_ERR;
        res.frame_last   = 1'b1;
        phase_nxt        = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = accept && has_res;
      out_nxt       = res;
    end else if (accept && has_res) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      target_r     <= 8'd0;
      sender_r     <= 8'd0;
      length_r     <= 8'd0;
      seen_r       <= 8'd0;
      sum_r        <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        target_r <= target_nxt;
        sender_r <= sender_nxt;
        length_r <= length_nxt;
        seen_r   <= seen_nxt;
        sum_r    <= sum_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_r.result_kind;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.payload_index  = out_r.payload_index;
  assign out_ch.target_address = out_r.target_address;
  assign out_ch.sender_address = out_r.sender_address;
  assign out_ch.frame_status   = out_r.frame_status;
  assign out_ch.frame_last     = out_r.frame_last;

endmodule

[dv/tb_serial_frame_receiver_checksum.sv]
module tb_serial_frame_receiver_checksum;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_TARGET, PH_SENDER, PH_ALIGN, PH_LENGTH, PH_PAYLOAD, PH_CHECK, PH_FOOTER
  } frame_phase_t;

  typedef enum int {SINK_STREAM, SINK_COIN, SINK_SPARSE, SINK_HICCUP} sink_mode_t;

  localparam int FLAW_NONE     = 0;
  localparam int FLAW_CHECKSUM = 1;
  localparam int FLAW_FOOTER   = 2;

  localparam int RANDOM_BYTES = 1200;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  serial_frame_receiver_checksum DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0]  pending_bytes[$];
  sfr_result_t expected_results[$];

  int error_count    = 0;
  int items_accepted = 0;
  int bytes_queued   = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  bit stall_hold     = 1'b0;

  frame_phase_t frame_phase   = PH_HUNT;
  logic [7:0]   hdr_target    = '0;
  logic [7:0]   hdr_sender    = '0;
  logic [7:0]   frame_len     = '0;
  logic [7:0]   payload_count = '0;
  logic [7:0]   frame_sum     = '0;

  sink_mode_t sink_mode = SINK_STREAM;
  int         mode_left = 0;
  int         tick      = 0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void deframe_byte(input logic [7:0] b);
    sfr_result_t r;
    r = '0;
    r.target_address = hdr_target[5:0];
    r.sender_address = hdr_sender[5:0];
    case (frame_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          frame_sum = b;
          payload_count = '0;
          frame_phase = PH_TARGET;
        end
      end
      PH_TARGET: begin
        hdr_target = b;
        frame_sum += b;
        frame_phase = PH_SENDER;
      end
      PH_SENDER: begin
        hdr_sender = b;
        frame_sum += b;
        frame_phase = PH_ALIGN;
      end
      PH_ALIGN: begin
        if (b != ALIGN_BYTE) begin
          frame_phase = PH_HUNT;
        end else begin
          frame_sum += b;
          frame_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (hdr_target > ADDR_MAX || hdr_sender > ADDR_MAX) begin
          frame_phase = PH_HUNT;
        end else begin
          frame_len = b;
          payload_count = '0;
          frame_sum += b;
          frame_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.result_kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = payload_count;
        r.frame_status = STATUS_OK;
        r.frame_last = 1'b0;
        expected_results.insert(expected_results.size(), r);
        frame_sum += b;
        payload_count++;
        if (payload_count == frame_len) frame_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b != 8'd1 - frame_sum) begin
          r.result_kind = KIND_FRAME_END;
          r.frame_status = STATUS_CHK_ERR;
          r.frame_last = 1'b1;
          expected_results.insert(expected_results.size(), r);
          frame_phase = PH_HUNT;
        end else begin
          frame_phase = PH_FOOTER;
        end
      end
      default: begin
        r.result_kind = KIND_FRAME_END;
        r.frame_status = (b == FOOTER_BYTE) ? STATUS_OK : STATUS_FOOTER_ERR;
        r.frame_last = 1'b1;
        expected_results.insert(expected_results.size(), r);
        frame_phase = PH_HUNT;
      end
    endcase
  endfunction

  function automatic string fmt_result(input sfr_result_t r);
    return $sformatf("kind %0d byte %02h idx %0d tgt %0d snd %0d status %0d last %0d",
                     r.result_kind, r.payload_byte, r.payload_index, r.target_address,
                     r.sender_address, r.frame_status, r.frame_last);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= pending_bytes[0];
          pending_bytes.delete(0);
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      tick++;
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (stall_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_STREAM: out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ch.ready <= (tick % 4 == 0);
          default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sfr_result_t got;
    sfr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result_kind = out_ch.result_kind;
      got.payload_byte = out_ch.payload_byte;
      got.payload_index = out_ch.payload_index;
      got.target_address = out_ch.target_address;
      got.sender_address = out_ch.sender_address;
      got.frame_status = out_ch.frame_status;
      got.frame_last = out_ch.frame_last;
      if (expected_results.size() == 0) begin
        note_error({"unexpected result: ", fmt_result(got)});
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got !== want)
          note_error({"mismatch: expected ", fmt_result(want), " got ", fmt_result(got)});
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    while (items_accepted < 400) @(negedge clk);
    stall_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    stall_hold = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] tgt, input logic [7:0] src,
                            input int unsigned len, input int flaw, input bit extremes);
    logic [7:0] sum;
    logic [7:0] data;
    logic [7:0] chk;
    logic [7:0] tail;
    sum = START_BYTE + tgt + src + ALIGN_BYTE + len[7:0];
    push_byte(START_BYTE);
    push_byte(tgt);
    push_byte(src);
    push_byte(ALIGN_BYTE);
    push_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      data = extremes ? {8{i[0]}} : 8'($urandom_range(0, 255));
      sum += data;
      push_byte(data);
    end
    chk = 8'd1 - sum;
    if (flaw == FLAW_CHECKSUM) begin
      chk ^= 8'($urandom_range(1, 255));
      push_byte(chk);
    end else begin
      push_byte(chk);
      if (flaw == FLAW_FOOTER) begin
        do tail = 8'($urandom_range(0, 255)); while (tail == FOOTER_BYTE);
        push_byte(tail);
      end else begin
        push_byte(FOOTER_BYTE);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_bytes.size() == 0 && !in_ch.valid && expected_results.size() == 0));
  endtask

  function automatic logic [7:0] pick_addr();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 32));
  endfunction

  initial begin
    int stop_at;
    int frame_no;
    int big_frame_at;
    int pick;
    int flaw;
    int unsigned len;
    bit mid_pause_done;
    logic [7:0] bad_align;

    // byte dropped while hunting
    push_byte(8'hFF);
    // wrong align byte
    push_byte(START_BYTE);
    push_byte(8'h05);
    push_byte(8'h07);
    push_byte(8'hFE);
    push_frame(8'd0, 8'd32, 2, FLAW_FOOTER, 1'b1);
    push_frame(8'd32, 8'd0, 0, FLAW_NONE, 1'b0);
    push_frame(8'd32, 8'd32, 0, FLAW_CHECKSUM, 1'b0);
    // candidate start right after the mismatch, header with addresses above range
    push_byte(START_BYTE);
    push_byte(8'hFF);
    push_byte(8'h21);
    push_byte(ALIGN_BYTE);
    push_byte(8'h03);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    stop_at = bytes_queued + RANDOM_BYTES;
    frame_no = 0;
    big_frame_at = $urandom_range(5, 60);
    mid_pause_done = 1'b0;
    while (bytes_queued < stop_at) begin
      if (!mid_pause_done && bytes_queued >= stop_at - RANDOM_BYTES / 2) begin
        wait_idle();
        mid_pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (frame_no == big_frame_at) begin
        push_frame(8'($urandom_range(0, 32)), 8'($urandom_range(0, 32)), 255, FLAW_NONE,
                   1'b0);
      end else if (pick < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
        case ($urandom_range(0, 9))
          0:       flaw = FLAW_CHECKSUM;
          1:       flaw = FLAW_FOOTER;
          default: flaw = FLAW_NONE;
        endcase
        push_frame(pick_addr(), pick_addr(), len, flaw, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        push_byte(START_BYTE);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
        do bad_align = 8'($urandom_range(0, 255)); while (bad_align == ALIGN_BYTE);
        push_byte(bad_align);
      end else begin
        push_byte(START_BYTE);
        if ($urandom_range(0, 1) == 0) begin
          push_byte(8'($urandom_range(33, 255)));
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(8'($urandom_range(0, 32)));
          push_byte(8'($urandom_range(33, 255)));
        end
        push_byte(ALIGN_BYTE);
        push_byte(8'($urandom_range(0, 255)));
      end
      frame_no++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[serial_frame_receiver_checksum] OK");
    end else begin
      $display("[serial_frame_receiver_checksum] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[serial_frame_receiver_checksum] ERROR");
    $finish;
  end

endmodule

[files.f]
sv/sfr_pkg.sv
sv/sfr_in_if.sv
sv/sfr_out_if.sv
sv/serial_frame_receiver_checksum.sv
dv/tb_serial_frame_receiver_checksum.sv
